// ===== src/typed_command_frame_parser_defines.svh =====
// Assertion helpers used by the parser source.
`ifndef TYPED_COMMAND_FRAME_PARSER_DEFINES_SVH
`define TYPED_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCFP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcfp_pkg;

    // Parser phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Frame kinds as reported on the result channel.
    localparam logic [1:0] KIND_BRIGHT  = 2'd0;
    localparam logic [1:0] KIND_PATTERN = 2'd1;
    localparam logic [1:0] KIND_PROFILE = 2'd2;
    localparam logic [1:0] KIND_STRIPE  = 2'd3;

    // Acceptance limits.
    localparam logic [7:0] BRIGHT_MAX   = 8'd100;
    localparam logic [7:0] STRIPE_LIMIT = 8'd15;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_CODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_CODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_CODE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_LENGTH  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_LENGTH   = 3'd6;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  brightness_code;
        logic [7:0]  pattern_code;
        logic [7:0]  profile_code;
        logic [7:0]  stripe_code;
        logic [15:0] profile_length;
        logic [15:0] stripe_length;
    } cfg_t;

    // Values after reset.
    localparam cfg_t CFG_RESET = '{
        start_code:      8'd0,
        brightness_code: 8'd1,
        pattern_code:    8'd2,
        profile_code:    8'd3,
        stripe_code:     8'd4,
        profile_length:  16'd96,
        stripe_length:   16'd10241
    };

endpackage

`default_nettype wire

// ===== src/tcfp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcfp_cfg_regs
    import tcfp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; writes beyond the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_START_CODE:      cfg_next.start_code      = cfg_wdata[7:0];
                REG_BRIGHTNESS_CODE: cfg_next.brightness_code = cfg_wdata[7:0];
                REG_PATTERN_CODE:    cfg_next.pattern_code    = cfg_wdata[7:0];
                REG_PROFILE_CODE:    cfg_next.profile_code    = cfg_wdata[7:0];
                REG_STRIPE_CODE:     cfg_next.stripe_code     = cfg_wdata[7:0];
                REG_PROFILE_LENGTH:  cfg_next.profile_length  = cfg_wdata;
                REG_STRIPE_LENGTH:   cfg_next.stripe_length   = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with synchronous reset to the default codes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/typed_command_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A payload byte appears on the result channel in the cycle after its input beat is taken.
// Throughput: one input byte per cycle unless a waiting result is not taken; the parser
// state update and a one-entry output register set this.
// Reset (aresetn low, synchronous): parser returns to idle, no result is pending and
// all configuration registers take their default codes and lengths.

`include "typed_command_frame_parser_defines.svh"

module typed_command_frame_parser
    import tcfp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,   // [7:0] data_byte, [23:8] offset
    output logic                        m_tlast,   // last
    output logic [2:0]                  m_tuser    // [1:0] frame_kind, [2] accepted
);

    cfg_t cfg;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] expected_reg, expected_next;
    logic [7:0]  first_reg, first_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [15:0] out_offset_reg;
    logic [1:0]  out_kind_reg;
    logic        out_last_reg;
    logic        out_acc_reg;

    logic        s_accept;
    logic        emit;
    logic        fin;
    logic        acc;
    logic [7:0]  rx_byte;
    logic [7:0]  first_val;
    logic [16:0] count_inc;
    logic [15:0] sel_len;
    logic [1:0]  sel_kind;
    logic        sel_hit;

    tcfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Take a beat whenever the output register is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign rx_byte  = s_tdata;

    // Type decode in priority order: profile, stripe, brightness, pattern.
    always_comb begin
        sel_hit  = 1'b1;
        sel_kind = KIND_BRIGHT;
        sel_len  = 16'd1;
        if (rx_byte == cfg.profile_code) begin
            sel_kind = KIND_PROFILE;
            sel_len  = cfg.profile_length;
        end else if (rx_byte == cfg.stripe_code) begin
            sel_kind = KIND_STRIPE;
            sel_len  = cfg.stripe_length;
        end else if (rx_byte == cfg.brightness_code) begin
            sel_kind = KIND_BRIGHT;
        end else if (rx_byte == cfg.pattern_code) begin
            sel_kind = KIND_PATTERN;
        end else begin
            sel_hit = 1'b0;
        end
    end

    // Payload position and acceptance check on the final byte.
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign fin       = (count_inc == {1'b0, expected_reg});
    assign first_val = (count_reg == 16'd0) ? rx_byte : first_reg;

    always_comb begin
        acc = 1'b0;
        if (fin) begin
            case (kind_reg)
                KIND_BRIGHT:  acc = (first_val <= BRIGHT_MAX);
                KIND_PATTERN: acc = 1'b1;
                KIND_PROFILE: acc = 1'b1;
                default:      acc = (first_val < STRIPE_LIMIT);
            endcase
        end
    end

    // Parser state update for one accepted beat.
    always_comb begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        first_next    = first_reg;
        emit          = 1'b0;
        if (s_accept) begin
            if (phase_reg != PH_DATA && rx_byte == cfg.start_code) begin
                phase_next    = PH_TYPE;
                count_next    = 16'd0;
                expected_next = 16'd0;
            end else if (phase_reg == PH_TYPE) begin
                if (sel_hit && sel_len != 16'd0) begin
                    phase_next    = PH_DATA;
                    kind_next     = sel_kind;
                    expected_next = sel_len;
                    count_next    = 16'd0;
                end else begin
                    phase_next    = PH_IDLE;
                    kind_next     = KIND_BRIGHT;
                    count_next    = 16'd0;
                    expected_next = 16'd0;
                end
            end else if (phase_reg == PH_DATA && count_reg < expected_reg) begin
                emit       = 1'b1;
                first_next = first_val;
                if (fin) begin
                    phase_next    = PH_IDLE;
                    kind_next     = KIND_BRIGHT;
                    count_next    = 16'd0;
                    expected_next = 16'd0;
                end else begin
                    count_next = count_inc[15:0];
                end
            end else begin
                phase_next    = PH_IDLE;
                kind_next     = KIND_BRIGHT;
                count_next    = 16'd0;
                expected_next = 16'd0;
            end
        end
    end

    // Output register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_BRIGHT;
            count_reg     <= 16'd0;
            expected_reg  <= 16'd0;
            first_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            expected_reg  <= expected_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with each emitted byte.
    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            out_byte_reg   <= rx_byte;
            out_offset_reg <= count_reg;
            out_kind_reg   <= kind_reg;
            out_last_reg   <= fin;
            out_acc_reg    <= acc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_offset_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_acc_reg, out_kind_reg};

    // Checks on the parser state and the result register.
    `TCFP_ASSERT_IMPL(a_count_in_range, aclk, aresetn, phase_reg == PH_DATA, count_reg < expected_reg, "payload count reached the expected length")
    `TCFP_ASSERT_IMPL(a_count_zero_outside, aclk, aresetn, phase_reg != PH_DATA, count_reg == 16'd0, "payload count is not zero outside a payload")
    `TCFP_ASSERT_IMPL(a_acc_only_last, aclk, aresetn, out_valid_reg && !out_last_reg, !out_acc_reg, "accept flag set on a byte that is not last")
    `TCFP_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, s_accept && emit && fin, phase_reg == PH_IDLE && m_tvalid && m_tlast, "final payload byte did not end the frame")

endmodule

`default_nettype wire

// ===== bench/typed_command_frame_parser_test.sv =====
`timescale 1ns / 1ps

module typed_command_frame_parser_test;
    import tcfp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // One payload beat as it should leave the parser.
    typedef struct {
        logic [7:0]  data_byte;
        logic [15:0] offset;
        logic [1:0]  frame_kind;
        logic        last;
        logic        accepted;
    } payload_beat_t;

    // Frame tracking state of the parser.
    typedef struct {
        logic [1:0]  phase;
        logic [1:0]  kind;
        logic [15:0] count;
        logic [15:0] need;
        logic [7:0]  first;
    } frame_state_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tlast;
    logic [2:0]             m_tuser;

    byte_q_t       rx_bytes;
    payload_beat_t payload_due[$];
    cfg_t          shadow_cfg = CFG_RESET;
    frame_state_t  frame;
    bit            calm = 1'b0;
    int unsigned   send_wait = 0;
    int unsigned   stall = 0;
    int unsigned   mismatches = 0;
    int unsigned   bytes_taken = 0;
    int unsigned   beats_checked = 0;
    int unsigned   frames_ok = 0;
    int unsigned   frames_bad = 0;
    int unsigned   settings_applied = 0;

    typed_command_frame_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void frame_to_idle();
        frame.phase = PH_IDLE;
        frame.kind  = KIND_BRIGHT;
        frame.count = '0;
        frame.need  = '0;
    endfunction

    // Advance the frame state by one received byte and queue the payload beat it yields.
    function automatic void parse_rx_byte(input logic [7:0] b);
        payload_beat_t beat;
        logic          fin;
        if (frame.phase != PH_DATA && b == shadow_cfg.start_code) begin
            frame.phase = PH_TYPE;
            frame.count = '0;
            frame.need  = '0;
            return;
        end
        if (frame.phase == PH_TYPE) begin
            // Profile wins over stripe, stripe over brightness, brightness over pattern.
            if (b == shadow_cfg.profile_code) begin
                frame.kind = KIND_PROFILE;
                frame.need = shadow_cfg.profile_length;
            end else if (b == shadow_cfg.stripe_code) begin
                frame.kind = KIND_STRIPE;
                frame.need = shadow_cfg.stripe_length;
            end else if (b == shadow_cfg.brightness_code) begin
                frame.kind = KIND_BRIGHT;
                frame.need = 16'd1;
            end else if (b == shadow_cfg.pattern_code) begin
                frame.kind = KIND_PATTERN;
                frame.need = 16'd1;
            end else begin
                frame_to_idle();
                return;
            end
            if (frame.need == '0) begin
                frame_to_idle();
            end else begin
                frame.count = '0;
                frame.phase = PH_DATA;
            end
            return;
        end
        if (frame.phase != PH_DATA || frame.count >= frame.need) begin
            frame_to_idle();
            return;
        end
        if (frame.count == '0) frame.first = b;
        fin = (17'(frame.count) + 17'd1) == 17'(frame.need);
        beat.data_byte  = b;
        beat.offset     = frame.count;
        beat.frame_kind = frame.kind;
        beat.last       = fin;
        beat.accepted   = 1'b0;
        if (fin) begin
            case (frame.kind)
                KIND_BRIGHT: beat.accepted = (frame.first <= BRIGHT_MAX);
                KIND_STRIPE: beat.accepted = (frame.first < STRIPE_LIMIT);
                default:     beat.accepted = 1'b1;
            endcase
            frame_to_idle();
        end else begin
            frame.count = frame.count + 16'd1;
        end
        payload_due.push_back(beat);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Input driver: presents queued bytes, inserting random gaps between beats.
    always @(posedge aclk) begin : driver
        int unsigned gap;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else if (s_tvalid && s_tready) begin
            gap = pick_gap();
            if (gap == 0 && rx_bytes.size() != 0) begin
                s_tdata <= rx_bytes.pop_front();
            end else begin
                s_tvalid  <= 1'b0;
                send_wait <= gap;
            end
        end else if (!s_tvalid) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
            end else if (rx_bytes.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_bytes.pop_front();
            end
        end
    end

    // Result sink: random back-pressure on the output stream.
    always @(posedge aclk) begin : sink
        int unsigned gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall    <= 0;
        end else if (stall != 0) begin
            m_tready <= 1'b0;
            stall    <= stall - 1;
        end else begin
            gap = pick_gap();
            m_tready <= (gap == 0);
            if (gap != 0) stall <= gap - 1;
        end
    end

    // Monitor: check the output beat first, then update the prediction from the input beat.
    always @(posedge aclk) begin : monitor
        payload_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (payload_due.size() == 0) begin
                    $error("unexpected payload beat: data_byte %0d offset %0d",
                           m_tdata[7:0], m_tdata[23:8]);
                    mismatches++;
                end else begin
                    want = payload_due.pop_front();
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("offset", want.offset, m_tdata[23:8]);
                    check_field("frame_kind", want.frame_kind, m_tuser[1:0]);
                    check_field("last", want.last, m_tlast);
                    check_field("accepted", want.accepted, m_tuser[2]);
                    beats_checked++;
                    if (want.last && want.accepted) frames_ok++;
                    else if (want.last) frames_bad++;
                end
            end
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
                bytes_taken++;
            end
        end
    end

    task automatic feed(input byte_q_t seq);
        foreach (seq[i]) rx_bytes.push_back(seq[i]);
    endtask

    // Wait until every byte is taken and every payload beat has come out.
    task automatic drain();
        while (rx_bytes.size() != 0 || s_tvalid || payload_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Drain, then close any open frame so the parser is idle.
    task automatic settle();
        logic [7:0] b;
        drain();
        while (frame.phase != PH_IDLE) begin
            if (frame.phase == PH_DATA) begin
                repeat (frame.need - frame.count) rx_bytes.push_back(8'($urandom));
            end else begin
                b = 8'($urandom);
                while (b == shadow_cfg.start_code || b == shadow_cfg.brightness_code ||
                       b == shadow_cfg.pattern_code || b == shadow_cfg.profile_code ||
                       b == shadow_cfg.stripe_code) b++;
                rx_bytes.push_back(b);
            end
            drain();
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_CODE:      shadow_cfg.start_code      = value[7:0];
            REG_BRIGHTNESS_CODE: shadow_cfg.brightness_code = value[7:0];
            REG_PATTERN_CODE:    shadow_cfg.pattern_code    = value[7:0];
            REG_PROFILE_CODE:    shadow_cfg.profile_code    = value[7:0];
            REG_STRIPE_CODE:     shadow_cfg.stripe_code     = value[7:0];
            REG_PROFILE_LENGTH:  shadow_cfg.profile_length  = value;
            REG_STRIPE_LENGTH:   shadow_cfg.stripe_length   = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_setting(input cfg_t c);
        settle();
        write_reg(REG_START_CODE, 16'(c.start_code));
        write_reg(REG_BRIGHTNESS_CODE, 16'(c.brightness_code));
        write_reg(REG_PATTERN_CODE, 16'(c.pattern_code));
        write_reg(REG_PROFILE_CODE, 16'(c.profile_code));
        write_reg(REG_STRIPE_CODE, 16'(c.stripe_code));
        write_reg(REG_PROFILE_LENGTH, c.profile_length);
        write_reg(REG_STRIPE_LENGTH, c.stripe_length);
        settings_applied++;
    endtask

    // Queue one random frame; mostly well formed, the rest broken or idle noise.
    task automatic random_frame(output int unsigned used);
        int unsigned r;
        int unsigned len;
        logic [1:0]  k;
        logic [7:0]  code;
        logic [7:0]  b;
        byte_q_t     f;
        f = {};
        r = $urandom_range(0, 99);
        if (r < 82) begin
            k = 2'($urandom_range(0, 3));
            case (k)
                KIND_BRIGHT:  begin code = shadow_cfg.brightness_code; len = 1; end
                KIND_PATTERN: begin code = shadow_cfg.pattern_code; len = 1; end
                KIND_PROFILE: begin code = shadow_cfg.profile_code; len = shadow_cfg.profile_length; end
                default:      begin code = shadow_cfg.stripe_code; len = shadow_cfg.stripe_length; end
            endcase
            f.push_back(shadow_cfg.start_code);
            f.push_back(code);
            for (int unsigned i = 0; i < len; i++) begin
                r = $urandom_range(0, 9);
                // Bias the first byte toward the acceptance thresholds.
                if (i == 0 && k == KIND_BRIGHT && r < 5) b = 8'($urandom_range(95, 106));
                else if (i == 0 && k == KIND_STRIPE && r < 5) b = 8'($urandom_range(10, 20));
                else if (r == 9) b = shadow_cfg.start_code;
                else b = 8'($urandom);
                f.push_back(b);
            end
        end else if (r < 90) begin
            // Start code followed by an arbitrary type byte.
            f.push_back(shadow_cfg.start_code);
            f.push_back(8'($urandom));
        end else if (r < 95) begin
            // Start code alone; the next frame's start code restarts it.
            f.push_back(shadow_cfg.start_code);
        end else begin
            repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
        end
        used = (r < 95) ? f.size() : 0;
        feed(f);
    endtask

    // Directed cases, random phases under varied settings, one long stripe.
    initial begin : stimulus
        cfg_t        c;
        int unsigned budget;
        int unsigned n;
        frame_to_idle();
        frame.first = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset codes: brightness at and above its limit, a pattern whose byte equals
        // the start code, an unknown type, and a start code while waiting for the type.
        feed({8'h00, 8'h01, 8'd100, 8'h00, 8'h01, 8'd101, 8'h00, 8'h02, 8'h00,
              8'h00, 8'h09, 8'h00, 8'h00, 8'h01, 8'hFF});

        // Stripes just below and at the index limit, a start code inside a payload.
        c = '{start_code: 8'hFF, brightness_code: 8'h00, pattern_code: 8'h80,
              profile_code: 8'h7F, stripe_code: 8'h01, profile_length: 16'd1,
              stripe_length: 16'd3};
        apply_setting(c);
        feed({8'hFF, 8'h01, 8'h0E, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h0F, 8'h55, 8'hAA,
              8'hFF, 8'h7F, 8'hAA});

        // Shared type code with a zero profile length, then profile priority.
        c.brightness_code = 8'h33;
        c.stripe_code     = 8'h33;
        c.profile_code    = 8'h33;
        c.profile_length  = 16'd0;
        apply_setting(c);
        feed({8'hFF, 8'h33});
        c.profile_length = 16'd2;
        apply_setting(c);
        feed({8'hFF, 8'h33, 8'h07, 8'h08});

        // Random phases, each under its own register setting.
        for (int p = 0; p < 8; p++) begin
            c.start_code      = 8'($urandom);
            c.brightness_code = 8'($urandom);
            c.pattern_code    = 8'($urandom);
            c.profile_code    = 8'($urandom);
            c.stripe_code     = 8'($urandom);
            c.profile_length  = 16'($urandom_range(1, 12));
            c.stripe_length   = 16'($urandom_range(1, 12));
            case (p)
                0: begin
                    c.start_code     = 8'h00;
                    c.profile_length = 16'd1;
                    c.stripe_length  = 16'd1;
                end
                1: begin
                    c.start_code      = 8'h80;
                    c.brightness_code = 8'h00;
                    c.pattern_code    = 8'hFF;
                end
                2: begin
                    // Overlapping type codes exercise the priority order.
                    c.brightness_code = 8'($urandom_range(0, 2));
                    c.pattern_code    = 8'($urandom_range(0, 2));
                    c.profile_code    = 8'($urandom_range(0, 2));
                    c.stripe_code     = 8'($urandom_range(0, 2));
                    c.start_code      = 8'hFF;
                end
                3: begin
                    c.profile_length = 16'($urandom_range(40, 200));
                    c.stripe_length  = 16'($urandom_range(40, 200));
                end
                default: ;
            endcase
            apply_setting(c);
            calm   = (p == 4);
            budget = 0;
            while (budget < 180) begin
                random_frame(n);
                budget += n;
            end
        end

        // Largest profile length in the register, one long stripe without idling.
        c = '{start_code: 8'h5A, brightness_code: 8'h11, pattern_code: 8'h22,
              profile_code: 8'h3C, stripe_code: 8'hC3, profile_length: 16'hFFFF,
              stripe_length: 16'd200};
        apply_setting(c);
        calm = 1'b1;
        rx_bytes.push_back(8'h5A);
        rx_bytes.push_back(8'hC3);
        rx_bytes.push_back(8'($urandom_range(0, 30)));
        repeat (199) rx_bytes.push_back(8'($urandom));
        settle();
        calm = 1'b0;
        repeat (5) @(posedge aclk);

        $display("Took %0d input bytes under %0d register settings, checked %0d payload beats.",
                 bytes_taken, settings_applied, beats_checked);
        $display("Frames closed: %0d accepted, %0d rejected.", frames_ok, frames_bad);
        if (mismatches == 0 && payload_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/tcfp_pkg.sv
src/tcfp_cfg_regs.sv
src/typed_command_frame_parser.sv
bench/typed_command_frame_parser_test.sv
